// ===== rtl/pra_pkg.sv =====
`timescale 1ns / 1ps
package pra_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TRIG_STAGES = 16;

  localparam int W    = 32;
  localparam int CW   = 34;            // cordic x, y, z in q2.30 with headroom
  localparam int TW   = FRAC_BITS + 4; // rounded sine / cosine
  localparam int VW   = 35;            // offset from pivot
  localparam int PW   = VW + TW;       // product
  localparam int IDXW = 5;
  localparam int AW   = 36;            // angle reduction word
  localparam int RW   = FRAC_BITS + 10;

  localparam longint FULL    = longint'(360) << FRAC_BITS;
  localparam longint HALF    = longint'(180) << FRAC_BITS;
  localparam longint QUARTER = longint'(90) << FRAC_BITS;
  localparam longint KMUL    = ((longint'(1) << 31) + FULL - 1) / FULL;
  localparam longint KOFF    = KMUL * FULL;
  localparam int RED_STEPS   = $clog2(2 * KMUL + 1);
  localparam int RED_HI      = RED_STEPS / 2;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic signed [28:0]   DEG_TO_RAD  = 29'sd74961321;

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  typedef struct packed {
    logic signed [W-1:0] px, py, pz;
    logic signed [W-1:0] cx, cy, cz;
    logic signed [W-1:0] ax, ay, az;
  } item_t;

  typedef struct packed {
    item_t                it;
    logic                 neg;
    logic signed [CW-1:0] x, y, z;
  } cordic_t;

  typedef struct packed {
    item_t                it;
    logic signed [TW-1:0] c, s;
  } trig_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [IDXW-1:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = CW'(32'h3243F6A8);
      5'd1:  v = CW'(32'h1DAC6705);
      5'd2:  v = CW'(32'h0FADBAFC);
      5'd3:  v = CW'(32'h07F56EA6);
      5'd4:  v = CW'(32'h03FEAB76);
      5'd5:  v = CW'(32'h01FFD55B);
      5'd6:  v = CW'(32'h00FFFAAA);
      5'd7:  v = CW'(32'h007FFF55);
      5'd8:  v = CW'(32'h003FFFEA);
      5'd9:  v = CW'(32'h001FFFFD);
      5'd10: v = CW'(32'h000FFFFF);
      5'd11: v = CW'(32'h0007FFFF);
      5'd12: v = CW'(32'h0003FFFF);
      5'd13: v = CW'(32'h0001FFFF);
      5'd14: v = CW'(32'h0000FFFF);
      5'd15: v = CW'(32'h00007FFF);
      5'd16: v = CW'(32'h00003FFF);
      5'd17: v = CW'(32'h00001FFF);
      5'd18: v = CW'(32'h00000FFF);
      5'd19: v = CW'(32'h000007FF);
      5'd20: v = CW'(32'h000003FF);
      5'd21: v = CW'(32'h000001FF);
      5'd22: v = CW'(32'h000000FF);
      5'd23: v = CW'(32'h0000007F);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/point_rotate_about_axes_core.sv =====
`timescale 1ns / 1ps
// channel   signals                                       direction
// in        in_valid/in_ready, in_point_*, in_center_*,   input
//           in_angle_deg, in_axis_*
// out       out_valid/out_ready, out_rotated_*            output
//
// one item per cycle while the output is not stalled; the pipeline runs through
// angle reduction, the cordic cell row, a rounding stage and three 2-stage rotations
// each stage holds its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up while the output is stalled
// rst_n (synchronous, active low) clears the valid bits only
module point_rotate_about_axes_core import pra_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] in_point_x,
  input  logic signed [W-1:0] in_point_y,
  input  logic signed [W-1:0] in_point_z,
  input  logic signed [W-1:0] in_center_x,
  input  logic signed [W-1:0] in_center_y,
  input  logic signed [W-1:0] in_center_z,
  input  logic signed [W-1:0] in_angle_deg,
  input  logic signed [W-1:0] in_axis_x,
  input  logic signed [W-1:0] in_axis_y,
  input  logic signed [W-1:0] in_axis_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_rotated_x,
  output logic signed [W-1:0] out_rotated_y,
  output logic signed [W-1:0] out_rotated_z
);

  localparam int CS = 3;
  localparam int RS = CS + TRIG_STAGES;
  localparam int XS = RS + 1;
  localparam int YS = XS + 2;
  localparam int ZS = YS + 2;
  localparam int NS = ZS + 2;

  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   rdy;
  item_t         in_item;
  cordic_t       cq [TRIG_STAGES+1];
  cordic_t       cl;
  trig_t         trig_nxt, trig_r, tx, ty, tz;
  logic signed [CW-1:0] xn, yn, cr, sr;

  assign in_item = '{px: in_point_x, py: in_point_y, pz: in_point_z,
                     cx: in_center_x, cy: in_center_y, cz: in_center_z,
                     ax: in_axis_x, ay: in_axis_y, az: in_axis_z};

  // ready ripples back from the output through empty stages
  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = rdy[0];

  pra_front u_front (
    .clk      (clk),
    .en       (rdy[2:0]),
    .in_item  (in_item),
    .in_angle (in_angle_deg),
    .out_d    (cq[0])
  );

  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cordic
    pra_cordic_cell u_cell (
      .clk   (clk),
      .en    (rdy[CS+g]),
      .idx   (IDXW'(g)),
      .d_in  (cq[g]),
      .d_out (cq[g+1])
    );
  end

  // quadrant fix and rounding to the point format
  always_comb begin
    cl = cq[TRIG_STAGES];
    xn = cl.neg ? -cl.x : cl.x;
    yn = cl.neg ? -cl.y : cl.y;
    cr = (xn + (CW'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    sr = (yn + (CW'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    trig_nxt.it = cl.it;
    trig_nxt.c  = TW'(cr);
    trig_nxt.s  = TW'(sr);
  end

  always_ff @(posedge clk) begin
    if (rdy[RS]) begin
      trig_r <= trig_nxt;
    end
  end

  pra_rot u_rot_x (.clk(clk), .en(rdy[XS+:2]), .sel(AXIS_X), .d_in(trig_r), .d_out(tx));
  pra_rot u_rot_y (.clk(clk), .en(rdy[YS+:2]), .sel(AXIS_Y), .d_in(tx), .d_out(ty));
  pra_rot u_rot_z (.clk(clk), .en(rdy[ZS+:2]), .sel(AXIS_Z), .d_in(ty), .d_out(tz));

  assign out_valid     = v_r[NS-1];
  assign out_rotated_x = tz.it.px;
  assign out_rotated_y = tz.it.py;
  assign out_rotated_z = tz.it.pz;

`ifndef NO_ASSERTIONS
  a_room_means_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_ready)
    else $error("pipeline has an empty stage but refuses input");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(out_valid && out_ready))
    |=> $countones(v_r) == $past($countones(v_r)) + 1)
    else $error("accepted item not tracked");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && in_ready) && out_valid && out_ready)
    |=> $countones(v_r) == $past($countones(v_r)) - 1)
    else $error("delivered item not released");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((in_valid && in_ready) == (out_valid && out_ready))
    |=> $countones(v_r) == $past($countones(v_r)))
    else $error("item count drifted");
`endif

endmodule

// ===== rtl/pra_front.sv =====
`timescale 1ns / 1ps
module pra_front import pra_pkg::*; (
  input  logic                clk,
  input  logic [2:0]          en,
  input  item_t               in_item,
  input  logic signed [W-1:0] in_angle,
  output cordic_t             out_d
);

  logic [AW-1:0]        u0_nxt, u0_r, m1;
  item_t                it0_r, it1_r;
  logic signed [AW-1:0] rs;
  logic signed [RW-1:0] r1_nxt, r1_r;
  logic                 neg1_nxt, neg1_r;
  logic signed [RW+28:0] prod;
  cordic_t              d2_nxt, d2_r;

  // offset to a positive value, then strip high multiples of a full turn
  always_comb begin
    u0_nxt = {{(AW-W){in_angle[W-1]}}, in_angle} + AW'(KOFF);
    for (int k = RED_STEPS - 1; k >= RED_HI; k--) begin
      if (u0_nxt >= (AW'(FULL) << k)) u0_nxt = u0_nxt - (AW'(FULL) << k);
    end
  end

  always_comb begin
    m1 = u0_r;
    for (int k = RED_HI - 1; k >= 0; k--) begin
      if (m1 >= (AW'(FULL) << k)) m1 = m1 - (AW'(FULL) << k);
    end
    rs = signed'(m1);
    if (m1 >= AW'(HALF)) rs = rs - signed'(AW'(FULL));
    neg1_nxt = 1'b0;
    if (rs > signed'(AW'(QUARTER))) begin
      rs = rs - signed'(AW'(HALF));
      neg1_nxt = 1'b1;
    end else if (rs < -signed'(AW'(QUARTER))) begin
      rs = rs + signed'(AW'(HALF));
      neg1_nxt = 1'b1;
    end
    r1_nxt = RW'(rs);
  end

  always_comb begin
    prod     = (RW+29)'(r1_r) * (RW+29)'(DEG_TO_RAD);
    d2_nxt.it  = it1_r;
    d2_nxt.neg = neg1_r;
    d2_nxt.x   = CORDIC_GAIN;
    d2_nxt.y   = '0;
    d2_nxt.z   = CW'(prod >>> (FRAC_BITS + 2));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u0_r  <= u0_nxt;
      it0_r <= in_item;
    end
    if (en[1]) begin
      r1_r   <= r1_nxt;
      neg1_r <= neg1_nxt;
      it1_r  <= it0_r;
    end
    if (en[2]) begin
      d2_r <= d2_nxt;
    end
  end

  assign out_d = d2_r;

endmodule

// ===== rtl/pra_cordic_cell.sv =====
`timescale 1ns / 1ps
module pra_cordic_cell import pra_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [IDXW-1:0] idx,
  input  cordic_t         d_in,
  output cordic_t         d_out
);

  cordic_t              d_nxt, d_r;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    xs    = d_in.x >>> idx;
    ys    = d_in.y >>> idx;
    d_nxt = d_in;
    if (d_in.z >= 0) begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - atan_q30(idx);
    end else begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + atan_q30(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ===== rtl/pra_rot.sv =====
`timescale 1ns / 1ps
module pra_rot import pra_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  axis_t      sel,
  input  trig_t      d_in,
  output trig_t      d_out
);

  localparam logic signed [PW:0] RHALF = (PW+1)'(1) << (FRAC_BITS - 1);

  logic signed [W-1:0]  a, b;
  logic signed [W:0]    pa, pb;
  logic                 on;
  logic signed [VW-1:0] va, vb;
  trig_t                ta_r, tb_nxt, tb_r;
  logic signed [PW-1:0] pac_r, pbs_r, pas_r, pbc_r;
  logic signed [W:0]    pa_r, pb_r;
  logic                 on_r;
  logic signed [PW:0]   sa, sb, ra, rb;
  logic signed [W-1:0]  na, nb;

  // pick the plane and pivot; handled axes already count as zero
  always_comb begin
    case (sel)
      AXIS_X: begin
        a  = d_in.it.py;
        b  = d_in.it.pz;
        pa = (W+1)'(d_in.it.cy) + (W+1)'(d_in.it.ay);
        pb = (W+1)'(d_in.it.cz) + (W+1)'(d_in.it.az);
        on = d_in.it.ax != '0;
      end
      AXIS_Y: begin
        a  = d_in.it.pz;
        b  = d_in.it.px;
        pa = (W+1)'(d_in.it.cz) + (W+1)'(d_in.it.az);
        pb = (W+1)'(d_in.it.cx);
        on = d_in.it.ay != '0;
      end
      AXIS_Z: begin
        a  = d_in.it.px;
        b  = d_in.it.py;
        pa = (W+1)'(d_in.it.cx);
        pb = (W+1)'(d_in.it.cy);
        on = d_in.it.az != '0;
      end
      default: begin
        a  = d_in.it.px;
        b  = d_in.it.py;
        pa = '0;
        pb = '0;
        on = 1'b0;
      end
    endcase
    va = VW'(a) - VW'(pa);
    vb = VW'(b) - VW'(pb);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ta_r  <= d_in;
      pac_r <= PW'(va) * PW'(d_in.c);
      pbs_r <= PW'(vb) * PW'(d_in.s);
      pas_r <= PW'(va) * PW'(d_in.s);
      pbc_r <= PW'(vb) * PW'(d_in.c);
      pa_r  <= pa;
      pb_r  <= pb;
      on_r  <= on;
    end
  end

  always_comb begin
    sa = (PW+1)'(pac_r) - (PW+1)'(pbs_r);
    sb = (PW+1)'(pas_r) + (PW+1)'(pbc_r);
    ra = (sa + RHALF) >>> FRAC_BITS;
    rb = (sb + RHALF) >>> FRAC_BITS;
    na = ra[W-1:0] + pa_r[W-1:0];
    nb = rb[W-1:0] + pb_r[W-1:0];
    tb_nxt = ta_r;
    if (on_r) begin
      case (sel)
        AXIS_X: begin
          tb_nxt.it.py = na;
          tb_nxt.it.pz = nb;
        end
        AXIS_Y: begin
          tb_nxt.it.pz = na;
          tb_nxt.it.px = nb;
        end
        AXIS_Z: begin
          tb_nxt.it.px = na;
          tb_nxt.it.py = nb;
        end
        default: tb_nxt = ta_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tb_r <= tb_nxt;
    end
  end

  assign d_out = tb_r;

endmodule

// ===== tb/sv/point_rotate_about_axes_checker.sv =====
`timescale 1ns / 1ps
module point_rotate_about_axes_checker import pra_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic signed [W-1:0] in_point_x,
  input  logic signed [W-1:0] in_point_y,
  input  logic signed [W-1:0] in_point_z,
  input  logic signed [W-1:0] in_center_x,
  input  logic signed [W-1:0] in_center_y,
  input  logic signed [W-1:0] in_center_z,
  input  logic signed [W-1:0] in_angle_deg,
  input  logic signed [W-1:0] in_axis_x,
  input  logic signed [W-1:0] in_axis_y,
  input  logic signed [W-1:0] in_axis_z,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [W-1:0] out_rotated_x,
  input  logic signed [W-1:0] out_rotated_y,
  input  logic signed [W-1:0] out_rotated_z,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic signed [W-1:0] x, y, z;
  } point_t;

  point_t moved_q[$];

  localparam longint ATAN_TBL [0:23] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  // arithmetic shift of a longint is a floor shift
  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v);
    return fl_shr(v + (longint'(1) << (FRAC_BITS - 1)), FRAC_BITS);
  endfunction

  function automatic longint wrap_w(longint v);
    logic signed [W-1:0] t;
    t = v[W-1:0];
    return longint'(t);
  endfunction

  task automatic trig(input longint ang, output longint s, output longint c);
    longint r, x, y, z, nx;
    logic flip;
    flip = 1'b0;
    r = ang % FULL;
    if (r < 0) r += FULL;
    if (r >= HALF) r -= FULL;
    if (r > QUARTER) begin
      r -= HALF;
      flip = 1'b1;
    end else if (r < -QUARTER) begin
      r += HALF;
      flip = 1'b1;
    end
    z = fl_shr(r * 74961321, FRAC_BITS + 2);
    x = 652032874;
    y = 0;
    for (int i = 0; i < TRIG_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - fl_shr(y, i);
        y = y + fl_shr(x, i);
        z -= ATAN_TBL[i];
      end else begin
        nx = x + fl_shr(y, i);
        y = y - fl_shr(x, i);
        z += ATAN_TBL[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = fl_shr(x + (longint'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS);
    s = fl_shr(y + (longint'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS);
  endtask

  task automatic predict_rotation(output point_t res);
    longint px, py, pz, cx, cy, cz, ax, ay, az, s, c, ox, oy, oz, vx, vy, vz;
    px = in_point_x;  py = in_point_y;  pz = in_point_z;
    cx = in_center_x; cy = in_center_y; cz = in_center_z;
    ax = in_axis_x;   ay = in_axis_y;   az = in_axis_z;
    if (ax != 0 || ay != 0 || az != 0) begin
      trig(longint'(in_angle_deg), s, c);
      if (ax != 0) begin
        oy = cy + ay; oz = cz + az;
        vy = py - oy; vz = pz - oz;
        py = wrap_w(round_q(vy * c - vz * s) + oy);
        pz = wrap_w(round_q(vy * s + vz * c) + oz);
      end
      if (ay != 0) begin
        ox = cx; oz = cz + az;
        vx = px - ox; vz = pz - oz;
        px = wrap_w(round_q(vx * c + vz * s) + ox);
        pz = wrap_w(round_q(vz * c - vx * s) + oz);
      end
      if (az != 0) begin
        ox = cx; oy = cy;
        vx = px - ox; vy = py - oy;
        px = wrap_w(round_q(vx * c - vy * s) + ox);
        py = wrap_w(round_q(vx * s + vy * c) + oy);
      end
    end
    res.x = px[W-1:0];
    res.y = py[W-1:0];
    res.z = pz[W-1:0];
  endtask

  initial fail_count = 0;
  assign pending = moved_q.size();

  always @(posedge clk) begin
    point_t want;
    if (rst_n && in_valid && in_ready) begin
      predict_rotation(want);
      moved_q.push_back(want);
    end
    if (rst_n && out_valid && out_ready) begin
      if (moved_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected item: %0d %0d %0d",
                   out_rotated_x, out_rotated_y, out_rotated_z);
      end else begin
        want = moved_q.pop_front();
        if (want.x !== out_rotated_x || want.y !== out_rotated_y ||
            want.z !== out_rotated_z) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %0d %0d %0d got %0d %0d %0d",
                     want.x, want.y, want.z,
                     out_rotated_x, out_rotated_y, out_rotated_z);
        end
      end
    end
  end

endmodule

// ===== tb/sv/point_rotate_about_axes_core_tb.sv =====
`timescale 1ns / 1ps
module point_rotate_about_axes_core_tb import pra_pkg::*;;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [W-1:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [W-1:0] in_angle_deg = '0;
  logic signed [W-1:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] out_rotated_x, out_rotated_y, out_rotated_z;
  int fail_count, pending;
  logic long_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_rotate_about_axes_core uut (.*);
  point_rotate_about_axes_checker chk (.*);

  function automatic logic signed [W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return W'(32'sh80000000) + $urandom_range(0, 3);
      2: return W'(32'sh7FFFFFFF) - $urandom_range(0, 3);
      default: return $signed(W'($urandom_range(0, 32'h01FFFFFF))) - 32'sh00FFFFFF;
    endcase
  endfunction

  function automatic logic signed [W-1:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return W'($signed($urandom_range(0, 16)) * 45 - 360) <<< FRAC_BITS;
      default: return $signed(W'($urandom_range(0, 720 << FRAC_BITS)))
                      - (360 << FRAC_BITS);
    endcase
  endfunction

  function automatic logic signed [W-1:0] pick_axis();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return $urandom;
      default: return $signed(W'($urandom_range(0, 8))) - 4 <<< FRAC_BITS;
    endcase
  endfunction

  // valid drops only when a gap follows, so back to back items keep it high
  task automatic send_point(input logic signed [W-1:0] px, py, pz, cx, cy, cz,
                            ang, ax, ay, az);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;  in_point_y <= py;  in_point_z <= pz;
    in_center_x <= cx; in_center_y <= cy; in_center_z <= cz;
    in_angle_deg <= ang;
    in_axis_x <= ax;   in_axis_y <= ay;   in_axis_z <= az;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic signed [W-1:0] mx, mn, one;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    one = 32'sh00010000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // all axes zero passes through, single axes, all axes, extremes, angle wraps
    send_point(mx, mn, 1, 0, 0, 0, 30 * one, 0, 0, 0);
    send_point(one, 2 * one, 3 * one, 0, 0, 0, 90 * one, one, 0, 0);
    send_point(one, 2 * one, 3 * one, 0, 0, 0, 90 * one, 0, one, 0);
    send_point(one, 2 * one, 3 * one, 0, 0, 0, 90 * one, 0, 0, one);
    send_point(one, 2 * one, 3 * one, one, -one, 5, 45 * one, one, one, one);
    send_point(mx, mx, mx, mn, mn, mn, 180 * one, mx, mx, mx);
    send_point(mn, mn, mn, mx, mx, mx, -180 * one, mn, mn, mn);
    send_point(mx, mn, mx, 0, 0, 0, mx, -1, 1, -1);
    send_point(mn, mx, mn, 0, 0, 0, mn, 1, -1, 1);
    send_point(one, one, one, 0, 0, 0, 360 * one, one, one, one);
    send_point(one, one, one, 0, 0, 0, -90 * one, one, one, one);
    send_point(one, one, one, 0, 0, 0, 270 * one, one, one, one);
    send_point(one, one, one, 0, 0, 0, 91 * one, one, 0, one);
    send_point(one, one, one, 0, 0, 0, -91 * one, 0, one, one);
    send_point(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    send_point(0, 0, 0, 0, 0, 0, 0, one, one, one);
    for (int n = 0; n < 700; n++) begin
      if (n == 300) long_hold = 1'b1;
      send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord(), pick_angle(), pick_axis(),
                 pick_axis(), pick_axis());
    end
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== point_rotate_about_axes_core.f =====
rtl/pra_pkg.sv
rtl/pra_front.sv
rtl/pra_cordic_cell.sv
rtl/pra_rot.sv
rtl/point_rotate_about_axes_core.sv
tb/sv/point_rotate_about_axes_checker.sv
tb/sv/point_rotate_about_axes_core_tb.sv
